/* rtl/core/gnag_pkg.sv */
`default_nettype none

package gnag_pkg;

  // Field widths.
  localparam int unsigned CoordW = 8;
  localparam int unsigned LenW   = 9;
  localparam int unsigned IndexW = 24;

  // Widths of the precomputed index terms.
  localparam int unsigned PlaneW = 17;
  localparam int unsigned RowW   = 16;

  // Configuration port.
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Coordinates are 8 bits wide, so no axis can hold more than this many cells.
  localparam int unsigned CoordLimit = 256;

  // Offsets of the 3x3x3 cube, numbered (dx+1)*9 + (dy+1)*3 + (dz+1).
  localparam int unsigned NumOffsets = 27;
  localparam int unsigned CentreBit  = 13;
  localparam int unsigned MaxResults = 26;
  localparam int unsigned CountW     = 5;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] RegLenX = 2'd0;
  localparam logic [1:0] RegLenY = 2'd1;
  localparam logic [1:0] RegLenZ = 2'd2;

  typedef logic [NumOffsets-1:0] offset_mask_t;

  typedef struct packed {
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] cell_z;
  } cell_t;

  typedef struct packed {
    logic [CoordW-1:0] nbr_x;
    logic [CoordW-1:0] nbr_y;
    logic [CoordW-1:0] nbr_z;
    logic [IndexW-1:0] nbr_index;
    logic              last;
  } nbr_t;

  // Which of the offsets -1, 0, +1 stay inside 0 .. len-1 along one axis.
  // Bit 0 is the -1 offset, bit 1 the centre, bit 2 the +1 offset.
  function automatic logic [2:0] axis_ok(input logic [CoordW-1:0] c,
                                         input logic [LenW-1:0] len);
    logic [LenW-1:0] c_ext;
    logic [2:0]      ok;
    c_ext = {1'b0, c};
    ok[0] = (c != '0) && (c_ext <= len);
    ok[1] = c_ext < len;
    ok[2] = (c_ext + LenW'(1)) < len;
    return ok;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/grid_neighbour_address_generator.sv */
// Channel | Direction | Handshake                   | Payload
// in      | input     | in_valid_i / in_stall_o     | in_data_i  (cell_t)
// out     | output    | out_valid_o / out_stall_i   | out_data_o (nbr_t)
// config  | input     | psel / penable / pready     | paddr, pwdata, prdata
//
// The offset generator issues one result per cycle while stage 1 can load; an item
// with no neighbours inside the grid issues none. The first result passes from the
// offset generator through stage 1, stage 2 and the output register of stage 3.
// Reset is asynchronous and clears all valid bits; the lengths return to 1.
// A stall on the output holds the output register; earlier stages keep moving into
// empty stages until the pipeline is full. in_stall_o is high while the generator
// still has neighbours of the current item to issue, but for the cycle that issues the last.
`default_nettype none

module grid_neighbour_address_generator
  import gnag_pkg::*;
#(
  parameter int unsigned MAX_GRID_LEN = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,

  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cell_t            in_data_i,

  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output nbr_t                  out_data_o,

  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  localparam int unsigned CapInt = (MAX_GRID_LEN < CoordLimit) ? MAX_GRID_LEN : CoordLimit;
  localparam logic [LenW-1:0] LenCap = LenW'(CapInt);

  // Configuration registers.
  logic [LenW-1:0] len_x_q, len_y_q, len_z_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_x_q <= LenW'(1);
      len_y_q <= LenW'(1);
      len_z_q <= LenW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegLenX: len_x_q <= pwdata[LenW-1:0];
        RegLenY: len_y_q <= pwdata[LenW-1:0];
        RegLenZ: len_z_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegLenX: prdata = DataW'(len_x_q);
      RegLenY: prdata = DataW'(len_y_q);
      RegLenZ: prdata = DataW'(len_z_q);
      default: prdata = '0;
    endcase
  end

  // Lengths saturated to what the coordinates and the parameter allow.
  logic [LenW-1:0] eff_x, eff_y, eff_z;

  assign eff_x = (len_x_q > LenCap) ? LenCap : len_x_q;
  assign eff_y = (len_y_q > LenCap) ? LenCap : len_y_q;
  assign eff_z = (len_z_q > LenCap) ? LenCap : len_z_q;

  // Cells per x plane, refreshed every cycle from the registers.
  logic [PlaneW-1:0] plane_q;
  logic [2*LenW-1:0] plane_full;

  assign plane_full = eff_y * eff_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= PlaneW'(1);
    end else begin
      plane_q <= plane_full[PlaneW-1:0];
    end
  end

  // Pipeline handshake: a stage loads when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // Offset generator: the mask of neighbours inside the grid that remain to issue.
  offset_mask_t      mask_q, new_mask, low_bit, rest_mask;
  logic [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [2:0]        ok_x, ok_y, ok_z;
  logic [2:0]        sel_x, sel_y, sel_z;
  logic              gen_busy, issue, in_take;

  assign ok_x = axis_ok(in_data_i.cell_x, eff_x);
  assign ok_y = axis_ok(in_data_i.cell_y, eff_y);
  assign ok_z = axis_ok(in_data_i.cell_z, eff_z);

  always_comb begin
    for (int b = 0; b < NumOffsets; b++) begin
      new_mask[b] = ok_x[b / 9] & ok_y[(b / 3) % 3] & ok_z[b % 3];
    end
    new_mask[CentreBit] = 1'b0;
  end

  // Lowest pending offset, decoded into one-hot selects per axis.
  assign low_bit   = mask_q & (~mask_q + offset_mask_t'(1));
  assign rest_mask = mask_q & ~low_bit;

  always_comb begin
    sel_x = '0;
    sel_y = '0;
    sel_z = '0;
    for (int b = 0; b < NumOffsets; b++) begin
      sel_x[b / 9]       = sel_x[b / 9] | low_bit[b];
      sel_y[(b / 3) % 3] = sel_y[(b / 3) % 3] | low_bit[b];
      sel_z[b % 3]       = sel_z[b % 3] | low_bit[b];
    end
  end

  assign gen_busy   = mask_q != '0;
  assign issue      = gen_busy && rdy1;
  assign in_stall_o = gen_busy && !(issue && (rest_mask == '0));
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (in_take) begin
      mask_q <= new_mask;
    end else if (issue) begin
      mask_q <= rest_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cx_q <= in_data_i.cell_x;
      cy_q <= in_data_i.cell_y;
      cz_q <= in_data_i.cell_z;
    end
  end

  // Neighbour coordinate for the selected offset of one axis.
  logic [CoordW-1:0] nx, ny, nz;

  assign nx = sel_x[0] ? cx_q - CoordW'(1) : (sel_x[1] ? cx_q : cx_q + CoordW'(1));
  assign ny = sel_y[0] ? cy_q - CoordW'(1) : (sel_y[1] ? cy_q : cy_q + CoordW'(1));
  assign nz = sel_z[0] ? cz_q - CoordW'(1) : (sel_z[1] ? cz_q : cz_q + CoordW'(1));

  // Stage 1: neighbour coordinates and the last flag.
  logic [CoordW-1:0] x1_q, y1_q, z1_q;
  logic              last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      x1_q    <= nx;
      y1_q    <= ny;
      z1_q    <= nz;
      last1_q <= rest_mask == '0;
    end
  end

  // Stage 2: the two products of the linear index.
  logic [CoordW-1:0]        x2_q, y2_q, z2_q;
  logic                     last2_q;
  logic [IndexW-1:0]        px_q;
  logic [RowW-1:0]          py_q;
  logic [CoordW+PlaneW-1:0] px_full;
  logic [CoordW+LenW-1:0]   py_full;

  assign px_full = x1_q * plane_q;
  assign py_full = y1_q * eff_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      z2_q    <= z1_q;
      last2_q <= last1_q;
      px_q    <= px_full[IndexW-1:0];
      py_q    <= py_full[RowW-1:0];
    end
  end

  // Stage 3: sum of the index terms into the output register.
  nbr_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_q.nbr_x     <= x2_q;
      out_q.nbr_y     <= y2_q;
      out_q.nbr_z     <= z2_q;
      out_q.nbr_index <= px_q + IndexW'(py_q) + IndexW'(z2_q);
      out_q.last      <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/core/gnag_checker.sv */
`default_nettype none

module gnag_checker
  import gnag_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire nbr_t out_data_o
);

  logic                  out_xfer;
  logic [CountW-1:0]     cnt_q;
  logic                  mid_q;
  logic [3*CoordW-1:0]   prev_q;
  logic [3*CoordW-1:0]   cur_pos;

  assign out_xfer = out_valid_o && !out_stall_i;
  assign cur_pos  = {out_data_o.nbr_x, out_data_o.nbr_y, out_data_o.nbr_z};

  // Track results of the current item: how many so far and the previous position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mid_q  <= 1'b0;
      prev_q <= '0;
    end else if (out_xfer) begin
      cnt_q  <= out_data_o.last ? '0 : cnt_q + CountW'(1);
      mid_q  <= !out_data_o.last;
      prev_q <= cur_pos;
    end
  end

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or was withdrawn");

  // No item gives more than 26 results, so the 26th one closes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (cnt_q == CountW'(MaxResults - 1)) |-> out_data_o.last)
    else $error("item produced more than the maximum number of results");

  // Within one item the neighbours come in increasing (x, y, z) order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && mid_q |-> cur_pos > prev_q)
    else $error("neighbours out of order within one item");

  // Nothing is offered in the first cycle after reset.
  assert property (@(posedge clk_i) !$past(rst_ni) |-> !out_valid_o)
    else $error("result offered straight out of reset");

endmodule

bind grid_neighbour_address_generator gnag_checker u_gnag_checker (.*);

`default_nettype wire

/* dv/tb_grid_neighbour_address_generator.sv */
`timescale 1ns / 1ps

module tb_grid_neighbour_address_generator;
  import gnag_pkg::*;

  localparam int unsigned MaxGridLen  = 256;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseCells  = 43;

  // Block inputs start at known values.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  cell_t            in_data_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;

  logic             in_stall_o;
  logic             out_valid_o;
  nbr_t             out_data_o;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Testbench copy of the length registers.
  logic [LenW-1:0]  len_x = LenW'(1);
  logic [LenW-1:0]  len_y = LenW'(1);
  logic [LenW-1:0]  len_z = LenW'(1);

  cell_t            pending_cells[$];
  nbr_t             expected_nbrs[$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;

  int unsigned      burst_left = 8;
  int unsigned      gap_left   = 0;
  int unsigned      stall_timer = 0;
  int unsigned      stall_mode  = 0;

  grid_neighbour_address_generator #(
    .MAX_GRID_LEN(MaxGridLen)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Lengths above the coordinate range saturate.
  function automatic int unsigned clamp_len(input logic [LenW-1:0] raw);
    int unsigned lim;
    lim = (MaxGridLen < CoordLimit) ? MaxGridLen : CoordLimit;
    return (raw < lim) ? raw : lim;
  endfunction

  // Moves one axis by -1, 0 or +1 and tells whether the result is inside.
  function automatic bit step_axis(input int unsigned c, input int d,
                                   input int unsigned len, output int unsigned n);
    n = c;
    if (d < 0) begin
      if (c == 0) return 1'b0;
      n = c - 1;
    end else if (d > 0) begin
      n = c + 1;
    end
    return n < len;
  endfunction

  // Lists the in-grid neighbours of one centre cell in x, y, z offset order.
  function automatic void enqueue_neighbours(input cell_t c);
    nbr_t        found[$];
    nbr_t        nb;
    int unsigned lx, ly, lz, nx, ny, nz, idx;
    lx = clamp_len(len_x);
    ly = clamp_len(len_y);
    lz = clamp_len(len_z);
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dz = -1; dz <= 1; dz++) begin
          if (dx == 0 && dy == 0 && dz == 0) continue;
          if (!step_axis(c.cell_x, dx, lx, nx) || !step_axis(c.cell_y, dy, ly, ny) ||
              !step_axis(c.cell_z, dz, lz, nz)) continue;
          idx          = nx * (ly * lz) + ny * lz + nz;
          nb.nbr_x     = CoordW'(nx);
          nb.nbr_y     = CoordW'(ny);
          nb.nbr_z     = CoordW'(nz);
          nb.nbr_index = IndexW'(idx);
          nb.last      = 1'b0;
          found.push_back(nb);
        end
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_nbrs.push_back(found[i]);
  endfunction

  // Input driver: bursts of transfers separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) enqueue_neighbours(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cells.size() > 0) begin
          in_data_i  <= pending_cells.pop_front();
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor with its own stall pattern, picked at random from four modes.
  always @(posedge clk_i) begin
    nbr_t want;
    if (rst_ni) begin
      stall_timer++;
      if (stall_timer % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_timer % 3 == 0);
      endcase
      if (out_valid_o && !out_stall_i) begin
        if (expected_nbrs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected neighbour x=%0d y=%0d z=%0d index=%0d last=%0b",
                     $realtime, out_data_o.nbr_x, out_data_o.nbr_y, out_data_o.nbr_z,
                     out_data_o.nbr_index, out_data_o.last);
        end else begin
          want = expected_nbrs.pop_front();
          if (out_data_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"[%0t] neighbour mismatch: expected x=%0d y=%0d z=%0d index=%0d ",
                        "last=%0b, got x=%0d y=%0d z=%0d index=%0d last=%0b"},
                       $realtime, want.nbr_x, want.nbr_y, want.nbr_z, want.nbr_index,
                       want.last, out_data_o.nbr_x, out_data_o.nbr_y, out_data_o.nbr_z,
                       out_data_o.nbr_index, out_data_o.last);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] reg_idx, input logic [LenW-1:0] value);
    logic [DataW-1:0] word;
    word = '0;
    if ($urandom_range(0, 1) == 1) word = $urandom();
    word[LenW-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_lengths(input logic [LenW-1:0] lx, input logic [LenW-1:0] ly,
                             input logic [LenW-1:0] lz);
    write_reg(RegLenX, lx);
    write_reg(RegLenY, ly);
    write_reg(RegLenZ, lz);
    len_x = lx;
    len_y = ly;
    len_z = lz;
  endtask

  task automatic send_cell(input int unsigned x, input int unsigned y, input int unsigned z);
    cell_t c;
    c.cell_x = CoordW'(x);
    c.cell_y = CoordW'(y);
    c.cell_z = CoordW'(z);
    pending_cells.push_back(c);
  endtask

  // Waits until every transfer is out, then lets the pipeline settle. The check
  // runs a little after the edge so that the driver's updates of that edge are seen.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_cells.size() != 0 || in_valid_i || expected_nbrs.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Lengths lean toward small grids so that edges and corners dominate.
  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 6))
          0: return LenW'(0);
          1: return LenW'(1);
          2: return LenW'(2);
          3: return LenW'(255);
          4: return LenW'(256);
          5: return LenW'(257);
          default: return LenW'(511);
        endcase
      end
      1: return LenW'($urandom_range(0, 511));
      default: return LenW'($urandom_range(1, 8));
    endcase
  endfunction

  // Most centres lie in the grid or one step past it; the rest span the full range.
  function automatic int unsigned pick_coord(input logic [LenW-1:0] raw);
    int unsigned hi;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    hi = clamp_len(raw);
    if (hi > 255) hi = 255;
    return $urandom_range(0, hi);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lengths at their reset values: a single-cell grid.
    send_cell(0, 0, 0);
    send_cell(1, 1, 1);
    send_cell(255, 255, 255);
    wait_drained();

    // Small cube: full neighbourhood, corners, and a centre just outside.
    set_lengths(3, 3, 3);
    send_cell(1, 1, 1);
    send_cell(0, 0, 0);
    send_cell(2, 2, 2);
    send_cell(3, 3, 3);
    send_cell(0, 2, 1);
    wait_drained();

    // Largest grid: the far corner and mixed coordinate bits.
    set_lengths(256, 256, 256);
    send_cell(0, 0, 0);
    send_cell(255, 255, 255);
    send_cell(128, 0, 255);
    send_cell(255, 128, 0);
    send_cell(170, 85, 51);
    wait_drained();

    // A zero length leaves no cell inside the grid.
    set_lengths(0, 4, 4);
    send_cell(0, 0, 0);
    send_cell(1, 1, 1);
    wait_drained();

    // Oversized lengths saturate.
    set_lengths(511, 257, 300);
    send_cell(255, 255, 255);
    send_cell(254, 0, 1);
    wait_drained();

    // Flat, uneven grid.
    set_lengths(2, 1, 256);
    send_cell(0, 0, 0);
    send_cell(1, 0, 200);
    send_cell(0, 0, 255);
    wait_drained();

    // Random phases, each with its own grid shape.
    for (int p = 0; p < RandPhases; p++) begin
      set_lengths(pick_len(), pick_len(), pick_len());
      for (int i = 0; i < PhaseCells; i++)
        send_cell(pick_coord(len_x), pick_coord(len_y), pick_coord(len_z));
      wait_drained();
    end

    if (mismatch_count == 0 && expected_nbrs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
